>>> design/fcct_pkg.sv
package fcct_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned TBL_AW        = $clog2(TABLE_ENTRIES);

  // field widths
  localparam int unsigned CLW   = 16;  // cluster number / table entry
  localparam int unsigned CNTW  = 12;  // cluster_count, freed count
  localparam int unsigned SPCW  = 8;   // sectors per cluster
  localparam int unsigned SECW  = 32;  // sector address
  localparam int unsigned PRODW = CNTW + SPCW;

  localparam logic [CLW-1:0] ENTRY_FREE    = 16'h0000;
  localparam logic [CLW-1:0] ENTRY_EOC_MIN = 16'hFFF8;
  localparam logic [CLW-1:0] ENTRY_EOC     = 16'hFFFF;
  localparam logic [CLW-1:0] DATA_CL_BASE  = 16'd2;

  localparam logic [CNTW-1:0] CLUSTER_COUNT_RST = 12'd4094;
  localparam logic [SECW-1:0] DATA_START_RST    = 32'd0;
  localparam logic [SPCW-1:0] SPC_RST           = 8'd1;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_GET   = 2'd2,
    REQ_SET   = 2'd3
  } fcct_req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } fcct_status_e;

  typedef enum logic [1:0] {
    CFG_CLUSTER_COUNT = 2'd0,
    CFG_DATA_START    = 2'd1,
    CFG_SPC           = 2'd2
  } fcct_cfg_e;

  // controller -> datapath
  typedef struct packed {
    logic take;       // request channel ready
    logic clr_wr;     // clearing pass write
    logic init;       // start of a request
    logic set_bad;    // status out of range
    logic set_full;   // status table full
    logic rd_cl;      // get: read entry
    logic wr_cl;      // set: write entry
    logic scan;       // allocate: read next candidate
    logic claim;      // allocate: mark found entry end of chain
    logic link;       // allocate: link previous cluster
    logic walk;       // free: read and zero current entry
    logic walk_next;  // free: follow link
    logic get_cap;    // get: capture read data
    logic mul;        // sector offset product
    logic load_out;   // fill output register
  } fcct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic      in_valid;
    fcct_req_e req;
    logic      from_zero;
    logic      from_ok;
    logic      cl_ok;
    logic      cur_ok;
    logic      cur_live;
    logic      found;
    logic      clr_last;
    logic      out_free;
  } fcct_sts_t;

  function automatic logic in_range(input logic [CLW-1:0] c, input logic [CNTW-1:0] count);
    logic [CLW:0] lim;
    logic [CLW:0] cx;
    lim = {{(CLW+1-CNTW){1'b0}}, count} + (CLW+1)'(2);
    cx  = {1'b0, c};
    return (c >= DATA_CL_BASE) && (cx < lim) && (cx < (CLW+1)'(TABLE_ENTRIES));
  endfunction

endpackage

>>> design/fcct_if.sv
interface fcct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] cluster;
  logic [15:0] link_from;
  logic [15:0] entry_value;

  modport source (output valid, req_type, cluster, link_from, entry_value, input ready);
  modport sink   (input valid, req_type, cluster, link_from, entry_value, output ready);
endinterface

interface fcct_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_cluster;
  logic [1:0]  status;
  logic        end_of_chain;
  logic [11:0] freed_count;
  logic [31:0] sector_address;

  modport source (output valid, result_cluster, status, end_of_chain, freed_count,
                  sector_address, input ready);
  modport sink   (input valid, result_cluster, status, end_of_chain, freed_count,
                  sector_address, output ready);
endinterface

>>> design/fcct_datapath.sv
module fcct_datapath import fcct_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fcct_cmd_t    cmd_i,
  output fcct_sts_t    sts_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  fcct_req_if.sink     req,
  fcct_rsp_if.source   rsp
);

  logic [CLW-1:0] mem [TABLE_ENTRIES];

  logic [CNTW-1:0]   cnt_q;
  logic [SECW-1:0]   das_q;
  logic [SPCW-1:0]   spc_q;

  fcct_req_e         req_q;
  logic [CLW-1:0]    cl_q, from_q, val_q, cur_q, prev_q, res_q, sc_q, rdata_q;
  fcct_status_e      status_q;
  logic              eoc_q, sc_ok_q, pend_q;
  logic [CNTW-1:0]   freed_q;
  logic [PRODW-1:0]  prod_q;
  logic [TBL_AW-1:0] clr_q;

  logic              out_valid_q;
  logic [CLW-1:0]    out_res_q;
  fcct_status_e      out_status_q;
  logic              out_eoc_q;
  logic [CNTW-1:0]   out_freed_q;
  logic [SECW-1:0]   out_sec_q;

  logic              accept;
  logic              we, re;
  logic [TBL_AW-1:0] waddr, raddr;
  logic [CLW-1:0]    wdata;
  logic [CLW-1:0]    ofs;
  logic [SECW-1:0]   sector;

  assign accept    = req.valid && cmd_i.take;
  assign req.ready = cmd_i.take;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CLUSTER_COUNT_RST;
      das_q <= DATA_START_RST;
      spc_q <= SPC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLUSTER_COUNT: cnt_q <= cfg_data_i[CNTW-1:0];
        CFG_DATA_START:    das_q <= cfg_data_i[SECW-1:0];
        CFG_SPC:           spc_q <= cfg_data_i[SPCW-1:0];
        default: ;
      endcase
    end
  end

  // memory port muxing
  always_comb begin
    we    = 1'b1;
    waddr = cur_q[TBL_AW-1:0];
    wdata = ENTRY_FREE;
    if (cmd_i.clr_wr) begin
      waddr = clr_q;
    end else if (cmd_i.wr_cl) begin
      waddr = cl_q[TBL_AW-1:0];
      wdata = val_q;
    end else if (cmd_i.claim) begin
      waddr = prev_q[TBL_AW-1:0];
      wdata = ENTRY_EOC;
    end else if (cmd_i.link) begin
      waddr = from_q[TBL_AW-1:0];
      wdata = prev_q;
    end else if (!cmd_i.walk) begin
      we = 1'b0;
    end
  end

  assign re    = cmd_i.rd_cl || cmd_i.scan || cmd_i.walk;
  assign raddr = cmd_i.rd_cl ? cl_q[TBL_AW-1:0] : cur_q[TBL_AW-1:0];

  // read-first: a walk reads the old link while zeroing it
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + TBL_AW'(1);
      if (cmd_i.init)   pend_q <= 1'b0;
      if (cmd_i.scan)   pend_q <= 1'b1;
    end
  end

  assign ofs = sc_q - DATA_CL_BASE;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= fcct_req_e'(req.req_type);
      cl_q   <= req.cluster;
      from_q <= req.link_from;
      val_q  <= req.entry_value;
    end
    if (cmd_i.init) begin
      res_q    <= '0;
      status_q <= ST_OK;
      eoc_q    <= 1'b0;
      freed_q  <= '0;
      cur_q    <= (req_q == REQ_ALLOC) ? DATA_CL_BASE : cl_q;
      sc_q     <= cl_q;
      sc_ok_q  <= (req_q != REQ_ALLOC) && in_range(cl_q, cnt_q);
    end
    if (cmd_i.set_bad)  status_q <= ST_RANGE;
    if (cmd_i.set_full) status_q <= ST_FULL;
    if (cmd_i.scan) begin
      prev_q <= cur_q;
      cur_q  <= cur_q + CLW'(1);
    end
    if (cmd_i.claim) begin
      res_q   <= prev_q;
      sc_q    <= prev_q;
      sc_ok_q <= 1'b1;
    end
    if (cmd_i.walk)      freed_q <= freed_q + CNTW'(1);
    if (cmd_i.walk_next) cur_q <= rdata_q;
    if (cmd_i.get_cap) begin
      res_q <= rdata_q;
      eoc_q <= (rdata_q >= ENTRY_EOC_MIN);
    end
    if (cmd_i.mul) prod_q <= PRODW'(ofs[CNTW-1:0]) * PRODW'(spc_q);
  end

  assign sector = sc_ok_q ? (das_q + SECW'(prod_q)) : '0;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_res_q    <= res_q;
      out_status_q <= status_q;
      out_eoc_q    <= eoc_q;
      out_freed_q  <= freed_q;
      out_sec_q    <= sector;
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.result_cluster = out_res_q;
  assign rsp.status         = out_status_q;
  assign rsp.end_of_chain   = out_eoc_q;
  assign rsp.freed_count    = out_freed_q;
  assign rsp.sector_address = out_sec_q;

  always_comb begin
    sts_o.in_valid  = req.valid;
    sts_o.req       = req_q;
    sts_o.from_zero = (from_q == ENTRY_FREE);
    sts_o.from_ok   = in_range(from_q, cnt_q);
    sts_o.cl_ok     = in_range(cl_q, cnt_q);
    sts_o.cur_ok    = in_range(cur_q, cnt_q);
    sts_o.cur_live  = (cur_q >= DATA_CL_BASE) && (cur_q < ENTRY_EOC_MIN);
    sts_o.found     = pend_q && (rdata_q == ENTRY_FREE);
    sts_o.clr_last  = (clr_q == TBL_AW'(TABLE_ENTRIES - 1));
    sts_o.out_free  = !out_valid_q || rsp.ready;
  end

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> in_range(cur_q, cnt_q))
    else $error("chain walk touched an entry out of range");

  // the hit is seen in the cycle after the read, and the claim in the cycle after that
  a_claim_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.claim |-> pend_q && $past(cmd_i.scan, 2) && (rdata_q == ENTRY_FREE))
    else $error("allocate claimed an entry that was not read free");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || rsp.ready))
    else $error("result register overwritten before transfer");

  a_freed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (freed_q != {CNTW{1'b1}}))
    else $error("freed count would wrap");

endmodule

>>> design/fcct_ctrl.sv
module fcct_ctrl import fcct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fcct_sts_t sts_i,
  output fcct_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_DISPATCH = 11'b000_0000_0100,
    S_SCAN     = 11'b000_0000_1000,
    S_CLAIM    = 11'b000_0001_0000,
    S_LINK     = 11'b000_0010_0000,
    S_WALK     = 11'b000_0100_0000,
    S_WALK_NX  = 11'b000_1000_0000,
    S_GET_CAP  = 11'b001_0000_0000,
    S_MUL      = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } fcct_state_e;

  fcct_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (sts_i.in_valid) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        cmd_o.init = 1'b1;
        case (sts_i.req)
          REQ_ALLOC: begin
            if (!sts_i.from_zero && !sts_i.from_ok) begin
              cmd_o.set_bad = 1'b1;
              state_d       = S_MUL;
            end else begin
              state_d = S_SCAN;
            end
          end
          REQ_FREE: state_d = S_WALK;
          REQ_GET: begin
            if (sts_i.cl_ok) begin
              cmd_o.rd_cl = 1'b1;
              state_d     = S_GET_CAP;
            end else begin
              cmd_o.set_bad = 1'b1;
              state_d       = S_MUL;
            end
          end
          REQ_SET: begin
            if (sts_i.cl_ok) cmd_o.wr_cl = 1'b1;
            else             cmd_o.set_bad = 1'b1;
            state_d = S_MUL;
          end
          default: state_d = S_MUL;
        endcase
      end
      S_SCAN: begin
        if (sts_i.found) begin
          state_d = S_CLAIM;
        end else if (!sts_i.cur_ok) begin
          cmd_o.set_full = 1'b1;
          state_d        = S_MUL;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_CLAIM: begin
        cmd_o.claim = 1'b1;
        state_d     = sts_i.from_zero ? S_MUL : S_LINK;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = S_MUL;
      end
      S_WALK: begin
        if (!sts_i.cur_live) begin
          state_d = S_MUL;
        end else if (!sts_i.cur_ok) begin
          cmd_o.set_bad = 1'b1;
          state_d       = S_MUL;
        end else begin
          cmd_o.walk = 1'b1;
          state_d    = S_WALK_NX;
        end
      end
      S_WALK_NX: begin
        cmd_o.walk_next = 1'b1;
        state_d         = S_WALK;
      end
      S_GET_CAP: begin
        cmd_o.get_cap = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !sts_i.found && !sts_i.cur_ok) |=> state_q == S_MUL)
    else $error("scan ran past the last cluster");

  a_take_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take && sts_i.in_valid) |=> (state_q == S_DISPATCH) && !cmd_o.take)
    else $error("request taken while busy");

  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == S_CLEAR) |-> $past(sts_i.clr_last))
    else $error("clearing pass left early");

endmodule

>>> design/fat16_cluster_chain_table_top.sv
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   req_type, cluster, link_from, entry_value
// rsp       out  valid/ready   result_cluster, status, end_of_chain, freed_count,
//                              sector_address
// cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i (no read-back)
//
// One request in flight. A chain walk alternates a read-and-zero step with a
// follow-link step for each freed entry, because of the table's registered
// read; the allocate scan reads one entry a cycle.
// After reset a clearing pass writes every table entry to free, one a cycle;
// no request is taken meanwhile, config writes are.
// The result register lets the next request be taken while a result waits.
module fat16_cluster_chain_table_top import fcct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  fcct_req_if.sink    req,
  fcct_rsp_if.source  rsp
);

  fcct_cmd_t cmd;  // controller commands, one strobe per datapath action
  fcct_sts_t sts;  // range checks, scan hit, clear progress, output space

  // sequencer: clearing pass, request dispatch, scan and chain walk loops
  fcct_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // table memory, request and result registers, sector arithmetic
  fcct_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req),
    .rsp        (rsp)
  );

endmodule
